FILE: sv/arcp_pkg.sv
// arcp_pkg: shared types and constants for the ascii relay command parser
// no dependencies
`timescale 1ns / 1ps

package arcp_pkg;

    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam int unsigned REPLY_BYTES = 15;
    localparam int unsigned NEEDLES = 9;
    localparam int unsigned NDL_W = 4;

    // needle codes, also the bit index into the match vector
    typedef enum logic [NDL_W-1:0] {
        NDL_RD       = 4'd0,
        NDL_WR       = 4'd1,
        NDL_INPUTALL = 4'd2,
        NDL_RELAYCTL = 4'd3,
        NDL_CH1      = 4'd4,
        NDL_CH2      = 4'd5,
        NDL_CH3      = 4'd6,
        NDL_CH4      = 4'd7,
        NDL_ON       = 4'd8
    } t_ndl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_DONE
    } t_state;

    // scanner result: per token slot 1..4, which needles each token contains
    typedef struct packed {
        logic [8:0] tok1;
        logic [8:0] tok2;
        logic [8:0] tok3;
        logic [9:0] tok4;   // bit 9 holds "off"
    } t_match;

    // reply text bytes for index below 12
    function automatic logic [7:0] reply_head(input logic [3:0] i);
        logic [7:0] r;
        begin
            case (i)
                4'd0:  r = 8'h4d;
                4'd1:  r = 8'h45;
                4'd2:  r = 8'h2c;
                4'd3:  r = 8'h69;
                4'd4:  r = 8'h6e;
                4'd5:  r = 8'h70;
                4'd6:  r = 8'h75;
                4'd7:  r = 8'h74;
                4'd8:  r = 8'h61;
                4'd9:  r = 8'h6c;
                4'd10: r = 8'h6c;
                default: r = 8'h2c;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: sv/arcp_if.sv
// arcp_if: valid/ready channel interface with a generic payload
// depends on nothing
`timescale 1ns / 1ps

interface arcp_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/ascii_relay_command_parser.sv
// ascii_relay_command_parser: top level, frame store, sequencer and reply
// depends on arcp_pkg, arcp_if, arcp_ram, arcp_scan
`timescale 1ns / 1ps

// Parses ASCII command frames received one SPI byte per transaction and
// answers with one result per byte. A carriage return ending a valid frame
// starts a scan that reads the frame store one byte per cycle through its
// single read port. The frame store needs no clearing pass after reset; the
// input is not ready while a byte is at work or while its result waits.
module ascii_relay_command_parser #(
    parameter int FRAME_MAX = 30
) (
    input  logic i_clk,
    input  logic i_rst_n,
    arcp_if.sink   i_in,
    arcp_if.source o_out
);
    localparam int AW = $clog2(FRAME_MAX);
    localparam int CW = $clog2(FRAME_MAX + 1);

    arcp_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [3:0]    r_rlen, r_ridx;
    logic [15:0]   r_samp, r_lvl;
    logic [3:0]    r_relay;
    logic          r_ovld, r_load;
    logic [7:0]    r_tx;
    logic          r_rvld;
    logic          r_stop;

    logic          w_acc, w_we, w_scan_start, w_byte_vld, w_done;
    logic [7:0]    w_b, w_rdata;
    logic [AW-1:0] w_waddr, w_raddr;
    arcp_pkg::t_match w_m;

    assign w_acc = i_in.valid && i_in.ready;
    assign w_b   = i_in.data.rx_byte;
    assign i_in.ready = (r_st == arcp_pkg::ST_IDLE) && !r_ovld;

    // frame store
    assign w_we    = w_acc && r_rlen == 4'd0 && r_cnt < CW'(FRAME_MAX);
    assign w_waddr = r_cnt[AW-1:0];
    assign w_raddr = r_ptr[AW-1:0];

    arcp_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_b),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // read data valid in the cycle after a scan read; stop at first zero byte
    assign w_byte_vld = r_rvld && !r_stop && w_rdata != 8'h00;
    assign w_scan_start = w_acc && n_st == arcp_pkg::ST_SCAN;

    arcp_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_scan_start),
        .i_byte_vld(w_byte_vld), .i_byte(w_rdata), .o_match(w_m)
    );

    assign w_done = r_ptr == r_len;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            arcp_pkg::ST_IDLE:
                if (w_acc && r_rlen == 4'd0 && r_cnt < CW'(FRAME_MAX)
                    && r_cnt >= CW'(2) && w_b == arcp_pkg::CH_CR) begin
                    n_st = arcp_pkg::ST_SCAN;
                end
            arcp_pkg::ST_SCAN: if (w_done) n_st = arcp_pkg::ST_EXEC;
            arcp_pkg::ST_EXEC: n_st = arcp_pkg::ST_DONE;
            arcp_pkg::ST_DONE: if (!r_rvld) n_st = arcp_pkg::ST_IDLE;
            default: n_st = arcp_pkg::ST_IDLE;
        endcase
    end

    // frame counter and scan pointer
    always_comb begin
        n_cnt = r_cnt;
        n_ptr = r_ptr;
        if (w_acc) begin
            if (r_rlen != 4'd0) begin
                if (r_ridx >= r_rlen) n_cnt = '0;
            end else if (r_cnt >= CW'(FRAME_MAX)) begin
                n_cnt = '0;
            end else if (r_cnt == '0 && w_b != arcp_pkg::CH_M) begin
                n_cnt = '0;
            end else if (r_cnt == CW'(1) && w_b != arcp_pkg::CH_E) begin
                n_cnt = '0;
            end else if (r_cnt >= CW'(2) && w_b == arcp_pkg::CH_CR) begin
                n_cnt = '0;
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
            n_ptr = '0;
        end else if (r_st == arcp_pkg::ST_SCAN && !w_done) begin
            n_ptr = r_ptr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= arcp_pkg::ST_IDLE;
            r_cnt <= '0;
            r_len <= '0;
            r_ptr <= '0;
            r_rlen <= '0;
            r_ridx <= '0;
            r_samp <= '0;
            r_relay <= '0;
            r_ovld <= 1'b0;
            r_rvld <= 1'b0;
            r_stop <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_ptr <= n_ptr;
            // frame length including the carriage return
            if (w_scan_start) r_len <= r_cnt + CW'(1);
            r_rvld <= r_st == arcp_pkg::ST_SCAN && !w_done;
            if (w_scan_start) r_stop <= 1'b0;
            else if (r_rvld && w_rdata == 8'h00) r_stop <= 1'b1;
            if (o_out.valid && o_out.ready) r_ovld <= 1'b0;
            // reply sequencing on a plain transaction
            if (w_acc && n_st == arcp_pkg::ST_IDLE) begin
                r_ovld <= 1'b1;
                if (r_rlen != 4'd0) begin
                    if (r_ridx < r_rlen) begin
                        r_ridx <= r_ridx + 4'd1;
                    end else begin
                        r_rlen <= '0;
                        r_ridx <= '0;
                    end
                end
            end
            // command execution after the scan
            if (r_st == arcp_pkg::ST_EXEC) begin
                if (w_m.tok1[arcp_pkg::NDL_RD]) begin
                    if (w_m.tok2[arcp_pkg::NDL_INPUTALL]) begin
                        r_samp <= r_lvl;
                        r_rlen <= 4'(arcp_pkg::REPLY_BYTES);
                        r_ridx <= '0;
                    end
                end else if (w_m.tok1[arcp_pkg::NDL_WR]
                             && w_m.tok2[arcp_pkg::NDL_RELAYCTL]) begin
                    for (int c = 0; c < 4; c++) begin
                        if (w_m.tok3[arcp_pkg::NDL_CH1 + c]) begin
                            if (w_m.tok4[9]) r_relay[c] <= 1'b0;
                            else if (w_m.tok4[arcp_pkg::NDL_ON]) r_relay[c] <= 1'b1;
                        end
                    end
                end
            end
            if (r_st == arcp_pkg::ST_DONE && !r_rvld) r_ovld <= 1'b1;
        end
        if (w_acc) begin
            r_lvl <= i_in.data.input_levels;
            r_load <= r_rlen != 4'd0 && r_ridx < r_rlen;
            if (r_rlen != 4'd0 && r_ridx < r_rlen) begin
                if (r_ridx < 4'd12) r_tx <= arcp_pkg::reply_head(r_ridx);
                else if (r_ridx == 4'd12) r_tx <= r_samp[7:0];
                else if (r_ridx == 4'd13) r_tx <= r_samp[15:8];
                else r_tx <= arcp_pkg::CH_CR;
            end else begin
                r_tx <= 8'h00;
            end
        end
    end

    assign o_out.valid = r_ovld;
    assign o_out.data.tx_load = r_load;
    assign o_out.data.tx_byte = r_tx;
    assign o_out.data.relay_outputs = r_relay;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != arcp_pkg::ST_IDLE |-> !w_acc) else $error("accept while busy");
    a_ridx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ridx <= r_rlen) else $error("reply index past length");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(FRAME_MAX)) else $error("frame count overflow");
endmodule

FILE: sv/arcp_ram.sv
// arcp_ram: generic ram with one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module arcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/arcp_scan.sv
// arcp_scan: byte-serial token matcher, one frame byte per cycle while i_byte_vld is high
// depends on arcp_pkg
`timescale 1ns / 1ps

module arcp_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_byte_vld,
    input  logic [7:0]        i_byte,
    output arcp_pkg::t_match  o_match
);
    // one rolling window of the last 8 token bytes, shared by all needles
    logic [63:0] r_win, n_win;
    logic [2:0]  r_tok, n_tok;     // token slot number, saturates at 6
    logic        r_intok, n_intok;
    arcp_pkg::t_match r_m, n_m;
    logic [9:0]  w_hit;

    always_comb begin
        logic [63:0] w;
        w = {r_win[55:0], i_byte};
        w_hit = '0;
        w_hit[arcp_pkg::NDL_RD]       = w[15:0] == "rd";
        w_hit[arcp_pkg::NDL_WR]       = w[15:0] == "wr";
        w_hit[arcp_pkg::NDL_INPUTALL] = w[63:0] == "inputall";
        w_hit[arcp_pkg::NDL_RELAYCTL] = w[63:0] == "relayCtl";
        w_hit[arcp_pkg::NDL_CH1]      = w[23:0] == "ch1";
        w_hit[arcp_pkg::NDL_CH2]      = w[23:0] == "ch2";
        w_hit[arcp_pkg::NDL_CH3]      = w[23:0] == "ch3";
        w_hit[arcp_pkg::NDL_CH4]      = w[23:0] == "ch4";
        w_hit[arcp_pkg::NDL_ON]       = w[15:0] == "on";
        w_hit[9]                      = w[23:0] == "off";
    end

    // window, token counter and match flags
    always_comb begin
        logic [2:0] tk;
        n_win = r_win;
        n_tok = r_tok;
        n_intok = r_intok;
        n_m = r_m;
        tk = r_tok;
        if (i_start) begin
            n_win = '0;
            n_tok = '0;
            n_intok = 1'b0;
            n_m = '0;
        end else if (i_byte_vld) begin
            if (i_byte == arcp_pkg::CH_COMMA) begin
                n_win = '0;
                n_intok = 1'b0;
            end else begin
                if (!r_intok) begin
                    tk = (r_tok == 3'd6) ? r_tok : r_tok + 3'd1;
                end
                n_tok = tk;
                n_intok = 1'b1;
                n_win = {r_win[55:0], i_byte};
                // slot counts from 1: the first token is skipped, token counter value 2 is slot 1
                case (tk)
                    3'd2: n_m.tok1 = r_m.tok1 | w_hit[8:0];
                    3'd3: n_m.tok2 = r_m.tok2 | w_hit[8:0];
                    3'd4: n_m.tok3 = r_m.tok3 | w_hit[8:0];
                    3'd5: n_m.tok4 = r_m.tok4 | w_hit;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_intok <= 1'b0;
            r_m <= '0;
        end else begin
            r_tok <= n_tok;
            r_intok <= n_intok;
            r_m <= n_m;
        end
        r_win <= n_win;
    end

    assign o_match = r_m;
endmodule
